FILE: rtl/assert_macros.svh
// Assertion macros used by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/vna_pkg.sv
package vna_pkg;

   // Fixed field widths
   localparam int FUNC_W = 2;
   localparam int IDX_W  = 10;
   localparam int POS_W  = 16;
   localparam int NORM_W = 16;

   // Defaults of the top level parameters
   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_POS_BITS     = 16;
   localparam int DEF_ACC_BITS     = 24;

   // Queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;

   // Unit scaling: top magnitude bit, fraction bits of Q1.14, one in Q1.14
   localparam int NORM_TOP  = 23;
   localparam int FRAC_BITS = 14;
   localparam int UNIT_ONE  = 16384;
   localparam int MAG_W     = NORM_TOP + 1;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int QUOT_W    = FRAC_BITS + 1;
   localparam int NUM_W     = MAG_W + FRAC_BITS + 1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_TRI  = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_TRI  = 2'd1,
      OP_READ = 2'd2,
      OP_MISS = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [IDX_W-1:0]         vertex;
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [POS_W-1:0]  pz;
      logic [IDX_W-1:0]         ca;
      logic [IDX_W-1:0]         cb;
      logic [IDX_W-1:0]         cc;
   } item_type;

   typedef struct packed {
      logic                     ok;
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
   } unit_res_type;

endpackage

FILE: rtl/vertex_normal_accumulator.sv
// Channel   Ports                              Handshake
// req       req_func .. req_corner_c           taken when start high and busy low
// rsp       rsp_normal_vertex .. zero_normal   one cycle, marked by rsp_strobe
//
// A load writes the clamped position and clears the sums in the back part. A triangle
// reads its corner positions, forms the cross product and, after the scaling unit, updates
// each corner's sum; a read fetches the stored sum and runs the unit. The unit normalizes
// one bit per cycle, then forms the squares, the root and three divisions.
// Reset is synchronous and clears control state only; stores are undefined until written.
// busy rises when the two-entry queue is full; results cannot be held off.
`include "assert_macros.svh"

module vertex_normal_accumulator #(
   parameter int MAX_VERTICES = vna_pkg::DEF_MAX_VERTICES,
   parameter int POS_BITS     = vna_pkg::DEF_POS_BITS,
   parameter int ACC_BITS     = vna_pkg::DEF_ACC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [vna_pkg::FUNC_W-1:0]       req_func,
   input  logic [vna_pkg::IDX_W-1:0]        req_vertex_index,
   input  logic signed [vna_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [vna_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [vna_pkg::POS_W-1:0] req_pos_z,
   input  logic [vna_pkg::IDX_W-1:0]        req_corner_a,
   input  logic [vna_pkg::IDX_W-1:0]        req_corner_b,
   input  logic [vna_pkg::IDX_W-1:0]        req_corner_c,
   output logic                             rsp_strobe,
   output logic [vna_pkg::IDX_W-1:0]        rsp_normal_vertex,
   output logic signed [vna_pkg::NORM_W-1:0] rsp_normal_x,
   output logic signed [vna_pkg::NORM_W-1:0] rsp_normal_y,
   output logic signed [vna_pkg::NORM_W-1:0] rsp_normal_z,
   output logic                             rsp_zero_normal
);
   import vna_pkg::*;

   localparam int CROSS_BITS = (2 * POS_BITS + 2 > ACC_BITS) ? 2 * POS_BITS + 2 : ACC_BITS;

   logic     q_valid, q_pop;
   item_type q_item;

   vna_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .func         (req_func),
      .vertex_index (req_vertex_index),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .pos_z        (req_pos_z),
      .corner_a     (req_corner_a),
      .corner_b     (req_corner_b),
      .corner_c     (req_corner_c),
      .busy         (busy),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   vna_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .POS_BITS     (POS_BITS),
      .ACC_BITS     (ACC_BITS),
      .CROSS_BITS   (CROSS_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_normal_vertex (rsp_normal_vertex),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_zero_normal   (rsp_zero_normal)
   );

   `ASSERT_IMPLY(a_zero_flag, clock, reset, rsp_strobe && rsp_zero_normal, rsp_normal_x == 16'sd0 && rsp_normal_y == 16'sd0 && rsp_normal_z == 16'sd0, "zero flag with a nonzero normal")
   `ASSERT_IMPLY(a_nonzero, clock, reset, rsp_strobe && !rsp_zero_normal, rsp_normal_x != 16'sd0 || rsp_normal_y != 16'sd0 || rsp_normal_z != 16'sd0, "unit normal came out zero")
   `ASSERT_IMPLY(a_full_shows, clock, reset, busy, q_valid, "queue full but empty to the back part")
   `ASSERT_NEXT(a_full_holds, clock, reset, busy && !q_pop, busy, "full queue drained without a pop")

endmodule

FILE: rtl/vna_front.sv
module vna_front #(
   parameter int MAX_VERTICES = vna_pkg::DEF_MAX_VERTICES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [vna_pkg::FUNC_W-1:0]    func,
   input  logic [vna_pkg::IDX_W-1:0]     vertex_index,
   input  logic signed [vna_pkg::POS_W-1:0] pos_x,
   input  logic signed [vna_pkg::POS_W-1:0] pos_y,
   input  logic signed [vna_pkg::POS_W-1:0] pos_z,
   input  logic [vna_pkg::IDX_W-1:0]     corner_a,
   input  logic [vna_pkg::IDX_W-1:0]     corner_b,
   input  logic [vna_pkg::IDX_W-1:0]     corner_c,
   output logic                          busy,
   output logic                          q_valid,
   output vna_pkg::item_type             q_item,
   input  logic                          q_pop
);
   import vna_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   item_type        item;
   logic            keep, push;
   logic            vi_ok, tri_ok;

   assign busy    = (count_ff == CW'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = queue_ff[rd_ff];

   // Classify the item: drop what has no effect, mark reads that miss
   always_comb begin
      vi_ok  = (32'(vertex_index) < 32'(MAX_VERTICES));
      tri_ok = (32'(corner_a) < 32'(MAX_VERTICES)) && (32'(corner_b) < 32'(MAX_VERTICES))
               && (32'(corner_c) < 32'(MAX_VERTICES));
      item.vertex = vertex_index;
      item.px = pos_x;
      item.py = pos_y;
      item.pz = pos_z;
      item.ca = corner_a;
      item.cb = corner_b;
      item.cc = corner_c;
      item.op = OP_LOAD;
      keep = 1'b0;
      case (func_type'(func))
         FUNC_LOAD: begin
            item.op = OP_LOAD;
            keep = vi_ok;
         end
         FUNC_TRI: begin
            item.op = OP_TRI;
            keep = tri_ok;
         end
         FUNC_READ: begin
            item.op = vi_ok ? OP_READ : OP_MISS;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = start && !busy && keep;

   // Advance queue pointers and fill count
   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = q_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ff] <= item;
      end
   end

endmodule

FILE: rtl/vna_unit.sv
module vna_unit #(
   parameter int IN_BITS = 2 * vna_pkg::DEF_POS_BITS + 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic signed [IN_BITS-1:0] in_x,
   input  logic signed [IN_BITS-1:0] in_y,
   input  logic signed [IN_BITS-1:0] in_z,
   output logic                     done,
   output vna_pkg::unit_res_type    res
);
   import vna_pkg::*;

   localparam int MW = (IN_BITS > MAG_W + 1) ? IN_BITS : MAG_W + 1;

   typedef enum logic [5:0] {
      U_IDLE  = 6'b000001,
      U_NORM  = 6'b000010,
      U_SQ    = 6'b000100,
      U_ROOT  = 6'b001000,
      U_DLOAD = 6'b010000,
      U_DIV   = 6'b100000
   } ustate_type;

   ustate_type               state_ff, state_in;
   logic [MW-1:0]            mag_ff [3];
   logic                     neg_ff [3];
   logic [1:0]               cnt_ff;
   logic [4:0]               it_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W-1:0]         v_ff;
   logic [ROOT_W:0]          rem_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [ROOT_W-1:0]        dr_ff;
   logic [QUOT_W-1:0]        low_ff;
   logic [QUOT_W-1:0]        q_ff;
   logic signed [NORM_W-1:0] n_ff [3];
   logic                     ok_ff;
   logic                     done_ff;

   logic [MW-1:0]            orv;
   logic [MW-1:0]            msel;
   logic [ROOT_W+2:0]        rem_t, trial;
   logic [NUM_W-1:0]         num;
   logic [ROOT_W:0]          dt;
   logic                     ge;
   logic [QUOT_W-1:0]        qn, qc;
   logic signed [NORM_W-1:0] nval;

   function automatic logic [MW-1:0] mag_of(input logic signed [IN_BITS-1:0] v);
      logic [IN_BITS-1:0] a;
      a = v[IN_BITS-1] ? (~v + 1'b1) : v;
      return MW'(a);
   endfunction

   assign done = done_ff;
   assign res  = '{ok: ok_ff, nx: n_ff[0], ny: n_ff[1], nz: n_ff[2]};

   // Datapath helpers
   always_comb begin
      orv = mag_ff[0] | mag_ff[1] | mag_ff[2];
      case (cnt_ff)
         2'd0:    msel = mag_ff[0];
         2'd1:    msel = mag_ff[1];
         default: msel = mag_ff[2];
      endcase
      rem_t = {rem_ff, v_ff[SUM_W-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};
      num   = {1'b0, msel[MAG_W-1:0], FRAC_BITS'(0)} + NUM_W'(root_ff >> 1);
      dt    = {dr_ff, low_ff[QUOT_W-1]};
      ge    = (dt >= {1'b0, root_ff});
      qn    = {q_ff[QUOT_W-2:0], ge};
      qc    = (qn > QUOT_W'(UNIT_ONE)) ? QUOT_W'(UNIT_ONE) : qn;
      nval  = neg_ff[cnt_ff == 2'd0 ? 0 : (cnt_ff == 2'd1 ? 1 : 2)]
              ? -NORM_W'(qc) : NORM_W'(qc);
   end

   // Sequence: normalize, sum of squares, root, three divisions; a zero vector ends at normalize
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE:  if (go) state_in = U_NORM;
         U_NORM: begin
            if (orv == '0) begin
               state_in = U_IDLE;
            end else if (!(|orv[MW-1:NORM_TOP+1]) && orv[NORM_TOP]) begin
               state_in = U_SQ;
            end
         end
         U_SQ:    if (cnt_ff == 2'd3) state_in = U_ROOT;
         U_ROOT:  if (it_ff == 5'(ROOT_W - 1)) state_in = U_DLOAD;
         U_DLOAD: state_in = U_DIV;
         U_DIV: begin
            if (it_ff == 5'(QUOT_W - 1)) begin
               state_in = (cnt_ff == 2'd2) ? U_IDLE : U_DLOAD;
            end
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= 1'b0;
         if (state_ff == U_NORM && orv == '0) begin
            done_ff <= 1'b1;
         end
         if (state_ff == U_DIV && it_ff == 5'(QUOT_W - 1) && cnt_ff == 2'd2) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         U_IDLE: begin
            if (go) begin
               mag_ff[0] <= mag_of(in_x);
               mag_ff[1] <= mag_of(in_y);
               mag_ff[2] <= mag_of(in_z);
               neg_ff[0] <= in_x[IN_BITS-1];
               neg_ff[1] <= in_y[IN_BITS-1];
               neg_ff[2] <= in_z[IN_BITS-1];
            end
         end
         U_NORM: begin
            // shift all magnitudes until the top bit sits at NORM_TOP
            if (orv == '0) begin
               ok_ff <= 1'b0;
               for (int i = 0; i < 3; i++) n_ff[i] <= '0;
            end else if (|orv[MW-1:NORM_TOP+1]) begin
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
            end else if (!orv[NORM_TOP]) begin
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
            end else begin
               cnt_ff <= 2'd0;
               sum_ff <= '0;
            end
         end
         U_SQ: begin
            sq_ff  <= msel[MAG_W-1:0] * msel[MAG_W-1:0];
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff != 2'd0) begin
               sum_ff <= sum_ff + SUM_W'(sq_ff);
            end
            if (cnt_ff == 2'd3) begin
               v_ff    <= sum_ff + SUM_W'(sq_ff);
               rem_ff  <= '0;
               root_ff <= '0;
               it_ff   <= '0;
            end
         end
         U_ROOT: begin
            // one root digit per cycle
            v_ff  <= v_ff << 2;
            it_ff <= it_ff + 1'b1;
            if (rem_t >= trial) begin
               rem_ff  <= (ROOT_W + 1)'(rem_t - trial);
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= (ROOT_W + 1)'(rem_t);
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            if (it_ff == 5'(ROOT_W - 1)) begin
               cnt_ff <= 2'd0;
            end
         end
         U_DLOAD: begin
            dr_ff  <= ROOT_W'(num[NUM_W-1:QUOT_W]);
            low_ff <= num[QUOT_W-1:0];
            q_ff   <= '0;
            it_ff  <= '0;
         end
         U_DIV: begin
            // one quotient bit per cycle
            dr_ff  <= ge ? ROOT_W'(dt - {1'b0, root_ff}) : ROOT_W'(dt);
            low_ff <= low_ff << 1;
            q_ff   <= qn;
            it_ff  <= it_ff + 1'b1;
            if (it_ff == 5'(QUOT_W - 1)) begin
               case (cnt_ff)
                  2'd0:    n_ff[0] <= nval;
                  2'd1:    n_ff[1] <= nval;
                  default: n_ff[2] <= nval;
               endcase
               cnt_ff <= cnt_ff + 1'b1;
               ok_ff  <= 1'b1;
            end
         end
         default: begin
            ok_ff <= ok_ff;
         end
      endcase
   end

endmodule

FILE: rtl/vna_back.sv
module vna_back #(
   parameter int MAX_VERTICES = vna_pkg::DEF_MAX_VERTICES,
   parameter int POS_BITS     = vna_pkg::DEF_POS_BITS,
   parameter int ACC_BITS     = vna_pkg::DEF_ACC_BITS,
   parameter int CROSS_BITS   = 2 * vna_pkg::DEF_POS_BITS + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  vna_pkg::item_type             q_item,
   output logic                          q_pop,
   output logic                          rsp_strobe,
   output logic [vna_pkg::IDX_W-1:0]     rsp_normal_vertex,
   output logic signed [vna_pkg::NORM_W-1:0] rsp_normal_x,
   output logic signed [vna_pkg::NORM_W-1:0] rsp_normal_y,
   output logic signed [vna_pkg::NORM_W-1:0] rsp_normal_z,
   output logic                          rsp_zero_normal
);
   import vna_pkg::*;

   localparam int AW  = $clog2(MAX_VERTICES);
   localparam int E_W = POS_BITS + 1;
   localparam int P_W = 2 * E_W;

   typedef enum logic [10:0] {
      B_IDLE      = 11'b00000000001,
      B_LOAD      = 11'b00000000010,
      B_TRI_A     = 11'b00000000100,
      B_TRI_B     = 11'b00000001000,
      B_TRI_C     = 11'b00000010000,
      B_TRI_E     = 11'b00000100000,
      B_CROSS     = 11'b00001000000,
      B_UNIT_GO   = 11'b00010000000,
      B_UNIT_WAIT = 11'b00100000000,
      B_ACC_RD    = 11'b01000000000,
      B_ACC_WR    = 11'b10000000000
   } bstate_type;

   bstate_type                 state_ff, state_in;
   item_type                   item_ff;
   logic [1:0]                 cnt_ff;
   logic [3*POS_BITS-1:0]      pos_mem [MAX_VERTICES];
   logic [3*ACC_BITS-1:0]      acc_mem [MAX_VERTICES];
   logic [3*POS_BITS-1:0]      pos_rd_ff, pa_ff, pb_ff;
   logic [3*ACC_BITS-1:0]      acc_rd_ff;
   logic signed [E_W-1:0]      e1_ff [3];
   logic signed [E_W-1:0]      e2_ff [3];
   logic signed [P_W-1:0]      p1_ff, p2_ff;
   logic signed [CROSS_BITS-1:0] cr_ff [3];
   unit_res_type               f_ff;
   logic                       read_pend_ff;

   logic [AW-1:0]              pos_addr, acc_addr;
   logic                       pos_we, acc_we;
   logic [3*POS_BITS-1:0]      pos_wd;
   logic [3*ACC_BITS-1:0]      acc_wd;
   logic                       unit_go, unit_done;
   unit_res_type               unit_res;
   logic signed [CROSS_BITS-1:0] ux, uy, uz;
   logic [IDX_W-1:0]           corner;

   logic                       strobe_ff;
   logic [IDX_W-1:0]           vtx_ff;
   logic signed [NORM_W-1:0]   nx_ff, ny_ff, nz_ff;
   logic                       zero_ff;

   function automatic logic signed [POS_BITS-1:0] clamp_pos(input logic signed [POS_W-1:0] v);
      logic signed [24:0] w, hi, lo;
      w  = {{(25 - POS_W){v[POS_W-1]}}, v};
      hi = 25'((1 << (POS_BITS - 1)) - 1);
      lo = -hi - 25'sd1;
      if (w > hi) w = hi;
      if (w < lo) w = lo;
      return POS_BITS'(w);
   endfunction

   function automatic logic [ACC_BITS-1:0] sat_add(input logic signed [ACC_BITS-1:0] acc,
                                                   input logic signed [NORM_W-1:0] f);
      logic signed [ACC_BITS:0] s, hi, lo;
      s  = (ACC_BITS + 1)'(acc) + (ACC_BITS + 1)'(f);
      hi = {2'b00, {(ACC_BITS - 1){1'b1}}};
      lo = {2'b11, {(ACC_BITS - 1){1'b0}}};
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      return ACC_BITS'(s);
   endfunction

   assign q_pop             = (state_ff == B_IDLE) && q_valid;
   assign rsp_strobe        = strobe_ff;
   assign rsp_normal_vertex = vtx_ff;
   assign rsp_normal_x      = nx_ff;
   assign rsp_normal_y      = ny_ff;
   assign rsp_normal_z      = nz_ff;
   assign rsp_zero_normal   = zero_ff;

   // Memory addresses and write data per state
   always_comb begin
      case (cnt_ff)
         2'd0:    corner = item_ff.ca;
         2'd1:    corner = item_ff.cb;
         default: corner = item_ff.cc;
      endcase
      pos_addr = AW'(item_ff.vertex);
      acc_addr = AW'(item_ff.vertex);
      if (state_ff == B_TRI_A) pos_addr = AW'(item_ff.ca);
      if (state_ff == B_TRI_B) pos_addr = AW'(item_ff.cb);
      if (state_ff == B_TRI_C) pos_addr = AW'(item_ff.cc);
      // corner updates walk the triangle; a read stays on its own vertex
      if ((state_ff == B_ACC_RD || state_ff == B_ACC_WR) && item_ff.op == OP_TRI) begin
         acc_addr = AW'(corner);
      end
      pos_we = (state_ff == B_LOAD);
      pos_wd = {clamp_pos(item_ff.pz), clamp_pos(item_ff.py), clamp_pos(item_ff.px)};
      acc_we = (state_ff == B_LOAD) || (state_ff == B_ACC_WR);
      if (state_ff == B_LOAD) begin
         acc_wd = '0;
      end else begin
         acc_wd = {sat_add(acc_rd_ff[3*ACC_BITS-1 -: ACC_BITS], f_ff.nz),
                   sat_add(acc_rd_ff[2*ACC_BITS-1 -: ACC_BITS], f_ff.ny),
                   sat_add(acc_rd_ff[ACC_BITS-1:0], f_ff.nx)};
      end
   end

   // Position and accumulator memories, registered read
   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_addr] <= pos_wd;
      pos_rd_ff <= pos_mem[pos_addr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_addr] <= acc_wd;
      acc_rd_ff <= acc_mem[acc_addr];
   end

   // Unit operands: cross product for triangles, stored sum for reads
   always_comb begin
      unit_go = (state_ff == B_UNIT_GO);
      if (item_ff.op == OP_TRI) begin
         ux = cr_ff[0];
         uy = cr_ff[1];
         uz = cr_ff[2];
      end else begin
         ux = CROSS_BITS'($signed(acc_rd_ff[ACC_BITS-1:0]));
         uy = CROSS_BITS'($signed(acc_rd_ff[2*ACC_BITS-1 -: ACC_BITS]));
         uz = CROSS_BITS'($signed(acc_rd_ff[3*ACC_BITS-1 -: ACC_BITS]));
      end
   end

   vna_unit #(
      .IN_BITS (CROSS_BITS)
   ) u_unit (
      .clock (clock),
      .reset (reset),
      .go    (unit_go),
      .in_x  (ux),
      .in_y  (uy),
      .in_z  (uz),
      .done  (unit_done),
      .res   (unit_res)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               case (q_item.op)
                  OP_LOAD: state_in = B_LOAD;
                  OP_TRI:  state_in = B_TRI_A;
                  OP_READ: state_in = B_ACC_RD;
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_LOAD:      state_in = B_IDLE;
         B_TRI_A:     state_in = B_TRI_B;
         B_TRI_B:     state_in = B_TRI_C;
         B_TRI_C:     state_in = B_TRI_E;
         B_TRI_E:     state_in = B_CROSS;
         B_CROSS:     if (cnt_ff == 2'd3) state_in = B_UNIT_GO;
         B_UNIT_GO:   state_in = B_UNIT_WAIT;
         B_UNIT_WAIT: begin
            if (unit_done) state_in = (item_ff.op == OP_TRI) ? B_ACC_RD : B_IDLE;
         end
         B_ACC_RD:    state_in = read_pend_ff ? B_UNIT_GO : B_ACC_WR;
         B_ACC_WR:    state_in = (cnt_ff == 2'd2) ? B_IDLE : B_ACC_RD;
         default:     state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (q_pop && q_item.op == OP_MISS)
                      || (state_ff == B_UNIT_WAIT && unit_done && item_ff.op != OP_TRI);
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               item_ff      <= q_item;
               cnt_ff       <= 2'd0;
               read_pend_ff <= (q_item.op == OP_READ);
               if (q_item.op == OP_MISS) begin
                  vtx_ff  <= q_item.vertex;
                  nx_ff   <= '0;
                  ny_ff   <= '0;
                  nz_ff   <= '0;
                  zero_ff <= 1'b1;
               end
            end
         end
         B_TRI_B: pa_ff <= pos_rd_ff;
         B_TRI_C: pb_ff <= pos_rd_ff;
         B_TRI_E: begin
            // edges from the first corner
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= E_W'($signed(pb_ff[i*POS_BITS +: POS_BITS]))
                           - E_W'($signed(pa_ff[i*POS_BITS +: POS_BITS]));
               e2_ff[i] <= E_W'($signed(pos_rd_ff[i*POS_BITS +: POS_BITS]))
                           - E_W'($signed(pa_ff[i*POS_BITS +: POS_BITS]));
            end
         end
         B_CROSS: begin
            // one component per cycle: products, then difference
            case (cnt_ff)
               2'd0: begin
                  p1_ff <= P_W'(e1_ff[1]) * P_W'(e2_ff[2]);
                  p2_ff <= P_W'(e1_ff[2]) * P_W'(e2_ff[1]);
               end
               2'd1: begin
                  p1_ff <= P_W'(e1_ff[2]) * P_W'(e2_ff[0]);
                  p2_ff <= P_W'(e1_ff[0]) * P_W'(e2_ff[2]);
                  cr_ff[0] <= CROSS_BITS'(p1_ff - p2_ff);
               end
               2'd2: begin
                  p1_ff <= P_W'(e1_ff[0]) * P_W'(e2_ff[1]);
                  p2_ff <= P_W'(e1_ff[1]) * P_W'(e2_ff[0]);
                  cr_ff[1] <= CROSS_BITS'(p1_ff - p2_ff);
               end
               default: begin
                  cr_ff[2] <= CROSS_BITS'(p1_ff - p2_ff);
               end
            endcase
            cnt_ff <= (cnt_ff == 2'd3) ? 2'd0 : cnt_ff + 1'b1;
         end
         B_UNIT_WAIT: begin
            if (unit_done) begin
               f_ff   <= unit_res;
               cnt_ff <= 2'd0;
               if (item_ff.op != OP_TRI) begin
                  vtx_ff  <= item_ff.vertex;
                  nx_ff   <= unit_res.nx;
                  ny_ff   <= unit_res.ny;
                  nz_ff   <= unit_res.nz;
                  zero_ff <= !unit_res.ok;
               end
            end
         end
         B_ACC_RD: read_pend_ff <= 1'b0;
         B_ACC_WR: cnt_ff <= cnt_ff + 1'b1;
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

endmodule
